// ===== rtl/csvg_pkg.sv =====
package csvg_pkg;

  localparam int IDX_W         = 18;
  localparam int RAD_W         = 16;
  localparam int ORD_W         = 3;
  localparam int POS_W         = 17;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_ORDER_DEF = 6;

  // vertex_index / 6 leaves a quotient below 2^16
  localparam int Q6_W = IDX_W - 2;

  // (idx >> 1) / 3 == ((idx >> 1) * DIV3_MUL) >> DIV3_SHIFT for every 17-bit value
  localparam int DIV3_W     = 19;
  localparam int DIV3_SHIFT = 20;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 19'd349526;

  localparam int NUM_FACES = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 1'd1;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [ORD_W-1:0] ORDER_RST  = 3'd0;

  typedef logic [2:0] corner_t;

  // per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    logic [2:0]       neg;
  } side_t;

  // quad corner order: (0,0),(1,0),(0,1),(0,1),(1,0),(1,1)
  function automatic logic corner_du(corner_t c);
    logic d;
    case (c)
      3'd1, 3'd4, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic corner_dv(corner_t c);
    logic d;
    case (c)
      3'd2, 3'd3, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/csvg_in_if.sv =====
interface csvg_in_if;
  logic                        valid;
  logic                        ready;
  logic [csvg_pkg::IDX_W-1:0]  vertex_index;

  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

// ===== rtl/csvg_out_if.sv =====
interface csvg_out_if;
  logic                              valid;
  logic                              ready;
  logic        [csvg_pkg::IDX_W-1:0] vertex_number;
  logic signed [csvg_pkg::POS_W-1:0] pos_x;
  logic signed [csvg_pkg::POS_W-1:0] pos_y;
  logic signed [csvg_pkg::POS_W-1:0] pos_z;
  logic                              index_valid;

  modport source (output valid, output vertex_number, output pos_x, output pos_y,
                  output pos_z, output index_valid, input ready);
  modport sink   (input valid, input vertex_number, input pos_x, input pos_y,
                  input pos_z, input index_valid, output ready);
endinterface

// ===== rtl/cube_sphere_vertex_generator_core.sv =====
// Channel  Port      Direction  Moves per transfer
// -------  --------  ---------  ----------------------------------------------------
// input    in_vtx    sink       vertex_index
// output   out_vtx   source     vertex_number, pos_x, pos_y, pos_z, index_valid
// config   cfg_*     in         cfg_we / cfg_index / cfg_wdata, one write per cycle
//
// One vertex per cycle while the output is not stalled; normalization uses the
// 16-stage bit-serial root (one result bit per stage, three lanes).
// Synchronous active-low reset clears the stage valid bits and sets radius to 1.0
// and order to 0. A stalled output holds only the last stage; upstream stages keep
// advancing into empty slots, so input transfers continue until the pipe is full.
module cube_sphere_vertex_generator_core #(
  parameter int MAX_ORDER = csvg_pkg::MAX_ORDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  csvg_in_if.sink                             in_vtx,
  csvg_out_if.source                          out_vtx,
  input  logic                                cfg_we,
  input  logic [csvg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csvg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = csvg_pkg::IDX_W;
  localparam int RAD_W = csvg_pkg::RAD_W;
  localparam int ORD_W = csvg_pkg::ORD_W;
  localparam int POS_W = csvg_pkg::POS_W;
  localparam int Q6_W  = csvg_pkg::Q6_W;
  localparam int PRD_W = IDX_W - 1 + csvg_pkg::DIV3_W;

  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int UW    = MAX_ORDER + 1;
  localparam int XW    = MAX_ORDER + 2;
  localparam int SQ_W  = 2 * MAX_ORDER + 1;
  localparam int LEN_W = 2 * MAX_ORDER + 2;
  localparam int R2_W  = 2 * RAD_W;
  localparam int RHS_W = SQ_W + R2_W + 2;

  localparam int S_ROOT = 5;
  localparam int NS     = S_ROOT + RAD_W + 1;
  localparam int S_OUT  = NS - 1;

  // ---------------- configuration
  logic [RAD_W-1:0] radius_r;
  logic [ORD_W-1:0] order_r;
  logic [OW-1:0]    ord;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= csvg_pkg::RADIUS_RST;
      order_r  <= csvg_pkg::ORDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csvg_pkg::CFG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        csvg_pkg::CFG_ORDER:  order_r  <= cfg_wdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign ord = (int'(order_r) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(order_r);

  // ---------------- stage control
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // a stage may load when it or any stage downstream of it has room
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      en[s] = out_vtx.ready || !(&(v_r | NS'((NS'(1) << s) - NS'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_vtx.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign in_vtx.ready = en[0];

  // ---------------- stage 0: input register
  logic [IDX_W-1:0] idx0_r;

  always_ff @(posedge clk) begin
    if (en[0]) idx0_r <= in_vtx.vertex_index;
  end

  // ---------------- stage 1: quotient by 6
  logic [PRD_W-1:0] div_prod;
  logic [IDX_W-1:0] idx1_r;
  logic [Q6_W-1:0]  q6_1_r;

  assign div_prod = PRD_W'(idx0_r[IDX_W-1:1]) * PRD_W'(csvg_pkg::DIV3_MUL);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      idx1_r <= idx0_r;
      q6_1_r <= Q6_W'(div_prod >> csvg_pkg::DIV3_SHIFT);
    end
  end

  // ---------------- stage 2: face, quad and corner to cube grid point
  logic [IDX_W-2:0]     three_q;
  logic [1:0]           rem3;
  csvg_pkg::corner_t    corner;
  logic [Q6_W-1:0]      face_w;
  logic [2:0]           face;
  logic                 ok;
  logic [UW-1:0]        uq, vq, uc, vc;
  logic [XW-1:0]        n_bits, u_bits, v_bits, f_bits;
  logic [XW-1:0]        cx, cy, cz;
  logic [XW-1:0]        cx2_r, cy2_r, cz2_r;
  logic                 ok2_r;
  logic [IDX_W-1:0]     idx2_r;

  always_comb begin
    three_q = (IDX_W-1)'({q6_1_r, 1'b0}) + (IDX_W-1)'(q6_1_r);
    rem3    = 2'(idx1_r[IDX_W-1:1] - three_q);
    corner  = {rem3, idx1_r[0]};
    face_w  = q6_1_r >> {ord, 1'b0};
    ok      = (face_w < Q6_W'(csvg_pkg::NUM_FACES));
    face    = face_w[2:0];

    // quad digits are MSB-first child numbers: even bits give u, odd bits give v
    uq = '0;
    vq = '0;
    for (int j = 0; j < MAX_ORDER; j++) begin
      uq[j] = (j < int'(ord)) && q6_1_r[2*j];
      vq[j] = (j < int'(ord)) && q6_1_r[2*j+1];
    end
    uc = uq + UW'(csvg_pkg::corner_du(corner));
    vc = vq + UW'(csvg_pkg::corner_dv(corner));

    n_bits = XW'(1) << ord;
    u_bits = {uc, 1'b0} - n_bits;
    v_bits = {vc, 1'b0} - n_bits;
    f_bits = face[0] ? n_bits : (XW'(0) - n_bits);

    if (face < 3'd2) begin
      cx = u_bits; cy = v_bits; cz = f_bits;
    end else if (face < 3'd4) begin
      cx = u_bits; cy = f_bits; cz = v_bits;
    end else begin
      cx = f_bits; cy = u_bits; cz = v_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cx2_r  <= cx;
      cy2_r  <= cy;
      cz2_r  <= cz;
      ok2_r  <= ok;
      idx2_r <= idx1_r;
    end
  end

  // ---------------- stage 3: squares
  function automatic logic [SQ_W-1:0] mag_sq(logic [XW-1:0] c);
    logic [XW-1:0]   m;
    logic [2*XW-1:0] p;
    m = c[XW-1] ? (XW'(0) - c) : c;
    p = (2*XW)'(m) * (2*XW)'(m);
    return p[SQ_W-1:0];
  endfunction

  logic [SQ_W-1:0]     sqx3_r, sqy3_r, sqz3_r;
  logic [R2_W-1:0]     r2_3_r;
  csvg_pkg::side_t     side3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sqx3_r      <= mag_sq(cx2_r);
      sqy3_r      <= mag_sq(cy2_r);
      sqz3_r      <= mag_sq(cz2_r);
      r2_3_r      <= R2_W'(radius_r) * R2_W'(radius_r);
      side3_r.idx <= idx2_r;
      side3_r.ok  <= ok2_r;
      side3_r.neg <= {cz2_r[XW-1], cy2_r[XW-1], cx2_r[XW-1]};
    end
  end

  // ---------------- stage 4: squared length and scaled targets
  logic [LEN_W-1:0]    len4_r;
  logic [RHS_W-1:0]    rhsx4_r, rhsy4_r, rhsz4_r;
  csvg_pkg::side_t     side4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      len4_r  <= LEN_W'(sqx3_r) + LEN_W'(sqy3_r) + LEN_W'(sqz3_r);
      rhsx4_r <= (RHS_W'(sqx3_r) * RHS_W'(r2_3_r)) << 2;
      rhsy4_r <= (RHS_W'(sqy3_r) * RHS_W'(r2_3_r)) << 2;
      rhsz4_r <= (RHS_W'(sqz3_r) * RHS_W'(r2_3_r)) << 2;
      side4_r <= side3_r;
    end
  end

  // ---------------- root stages
  logic [RAD_W-1:0] lo_x, lo_y, lo_z;
  csvg_pkg::side_t  side_r [RAD_W];

  csvg_norm_lane #(.MAX_ORDER(MAX_ORDER)) u_lane_x (
    .clk  (clk),
    .en   (en[S_ROOT +: RAD_W]),
    .len2 (len4_r),
    .rhs  (rhsx4_r),
    .lo   (lo_x)
  );

  csvg_norm_lane #(.MAX_ORDER(MAX_ORDER)) u_lane_y (
    .clk  (clk),
    .en   (en[S_ROOT +: RAD_W]),
    .len2 (len4_r),
    .rhs  (rhsy4_r),
    .lo   (lo_y)
  );

  csvg_norm_lane #(.MAX_ORDER(MAX_ORDER)) u_lane_z (
    .clk  (clk),
    .en   (en[S_ROOT +: RAD_W]),
    .len2 (len4_r),
    .rhs  (rhsz4_r),
    .lo   (lo_z)
  );

  always_ff @(posedge clk) begin
    if (en[S_ROOT]) side_r[0] <= side4_r;
    for (int i = 1; i < RAD_W; i++) begin
      if (en[S_ROOT+i]) side_r[i] <= side_r[i-1];
    end
  end

  // ---------------- output register
  function automatic logic [POS_W-1:0] signed_pos(logic [RAD_W-1:0] m, logic neg, logic ok);
    logic [POS_W-1:0] r;
    if (!ok)      r = '0;
    else if (neg) r = POS_W'(0) - POS_W'(m);
    else          r = POS_W'(m);
    return r;
  endfunction

  csvg_pkg::side_t  last;
  logic [IDX_W-1:0] num_r;
  logic [POS_W-1:0] px_r, py_r, pz_r;
  logic             iv_r;

  assign last = side_r[RAD_W-1];

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      num_r <= last.idx;
      px_r  <= signed_pos(lo_x, last.neg[0], last.ok);
      py_r  <= signed_pos(lo_y, last.neg[1], last.ok);
      pz_r  <= signed_pos(lo_z, last.neg[2], last.ok);
      iv_r  <= last.ok;
    end
  end

  assign out_vtx.valid         = v_r[S_OUT];
  assign out_vtx.vertex_number = num_r;
  assign out_vtx.pos_x         = $signed(px_r);
  assign out_vtx.pos_y         = $signed(py_r);
  assign out_vtx.pos_z         = $signed(pz_r);
  assign out_vtx.index_valid   = iv_r;

endmodule

// ===== rtl/csvg_norm_lane.sv =====
// Bit-serial rounding root, one result bit per stage, MSB first.
// Finds the largest lo with (2*lo-1)^2 * len2 <= rhs, tracking
// p = (2*lo-1)^2 * len2 and m = (2*lo-1) * len2 incrementally.
module csvg_norm_lane #(
  parameter int MAX_ORDER = csvg_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic [csvg_pkg::RAD_W-1:0]  en,
  input  logic [2*MAX_ORDER+1:0]      len2,
  input  logic [2*MAX_ORDER+34:0]     rhs,
  output logic [csvg_pkg::RAD_W-1:0]  lo
);

  localparam int RW    = csvg_pkg::RAD_W;
  localparam int LEN_W = 2 * MAX_ORDER + 2;
  localparam int RHS_W = 2 * MAX_ORDER + 35;
  localparam int PW    = 2 * MAX_ORDER + 39;

  logic signed [PW-1:0]    p_r   [RW];
  logic signed [PW-1:0]    m_r   [RW];
  logic        [RHS_W-1:0] rhs_r [RW];
  logic        [LEN_W-1:0] len_r [RW];
  logic        [RW-1:0]    lo_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    localparam int K = RW - 1 - i;

    logic signed [PW-1:0]    p_in;
    logic signed [PW-1:0]    m_in;
    logic signed [PW-1:0]    len_ext;
    logic signed [PW-1:0]    cand;
    logic        [RHS_W-1:0] rhs_in;
    logic        [LEN_W-1:0] len_in;
    logic        [RW-1:0]    lo_in;
    logic                    take;

    if (i == 0) begin : g_first
      // lo = 0 stands for t = -1
      always_comb begin
        len_in = len2;
        rhs_in = rhs;
        lo_in  = '0;
        p_in   = $signed(PW'(len2));
        m_in   = -$signed(PW'(len2));
      end
    end else begin : g_next
      always_comb begin
        len_in = len_r[i-1];
        rhs_in = rhs_r[i-1];
        lo_in  = lo_r[i-1];
        p_in   = p_r[i-1];
        m_in   = m_r[i-1];
      end
    end

    always_comb begin
      len_ext = $signed(PW'(len_in));
      // (t + 2b)^2 * len2 = p + 4b*m + 4b^2*len2, b = 2^K
      cand    = p_in + (m_in <<< (K + 2)) + (len_ext <<< (2 * K + 2));
      take    = (cand <= $signed(PW'(rhs_in)));
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        p_r[i]   <= take ? cand : p_in;
        m_r[i]   <= take ? (m_in + (len_ext <<< (K + 1))) : m_in;
        lo_r[i]  <= lo_in | (take ? (RW'(1) << K) : RW'(0));
        rhs_r[i] <= rhs_in;
        len_r[i] <= len_in;
      end
    end
  end

  assign lo = lo_r[RW-1];

endmodule

// ===== tb/sv/cube_sphere_vertex_generator_core_tb.sv =====
`timescale 1ns / 100ps

module cube_sphere_vertex_generator_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AFTER = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES = 8;

  typedef logic [csvg_pkg::IDX_W-1:0]      index_t;
  typedef logic [csvg_pkg::RAD_W-1:0]      radius_t;
  typedef logic [csvg_pkg::ORD_W-1:0]      order_t;
  typedef logic [csvg_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct {
    logic        [csvg_pkg::IDX_W-1:0] number;
    logic signed [csvg_pkg::POS_W-1:0] x;
    logic signed [csvg_pkg::POS_W-1:0] y;
    logic signed [csvg_pkg::POS_W-1:0] z;
    logic                              valid;
  } vertex_t;

  class vertex_book;
    // corner order (0,0),(1,0),(0,1),(0,1),(1,0),(1,1), bit c for corner c
    localparam logic [5:0] CORNER_U = 6'b110010;
    localparam logic [5:0] CORNER_V = 6'b101100;

    logic [csvg_pkg::RAD_W-1:0] radius_q88;
    logic [csvg_pkg::ORD_W-1:0] order_sel;
    vertex_t                    awaited[$];
    int                         mismatches;

    function new();
      radius_q88 = csvg_pkg::RADIUS_RST;
      order_sel  = csvg_pkg::ORDER_RST;
      mismatches = 0;
    endfunction

    function void set_radius(logic [csvg_pkg::RAD_W-1:0] r);
      radius_q88 = r;
    endfunction

    function void set_order(logic [csvg_pkg::ORD_W-1:0] o);
      order_sel = o;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // sign(a) * round(|a| * radius / sqrt(len2)), halves away from zero, exact
    function logic [csvg_pkg::POS_W-1:0] normalize_axis(int a, longint unsigned len2);
      longint unsigned mag, rhs, lo, hi, mid, t, rad;
      logic [csvg_pkg::POS_W-1:0] res;
      rad = 64'(radius_q88);
      mag = (a < 0) ? 64'(-a) : 64'(a);
      rhs = 4 * mag * mag * rad * rad;
      lo = 0;
      hi = rad;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * len2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      res = lo[csvg_pkg::POS_W-1:0];
      if (a < 0) res = -res;
      return res;
    endfunction

    function vertex_t project_vertex(logic [csvg_pkg::IDX_W-1:0] idx);
      int unsigned ix, ord, per_face, face, rem, quad, corner, uq, vq, n, j;
      int u, v, fx, x, y, z;
      longint unsigned len2;
      vertex_t e;
      ix = 32'(idx);
      ord = (order_sel > csvg_pkg::MAX_ORDER_DEF) ? csvg_pkg::MAX_ORDER_DEF : 32'(order_sel);
      per_face = 6 << (2 * ord);
      e.number = idx;
      e.x = '0;
      e.y = '0;
      e.z = '0;
      e.valid = 1'b0;
      if (ix >= csvg_pkg::NUM_FACES * per_face) return e;
      face = ix / per_face;
      rem = ix % per_face;
      quad = rem / 6;
      corner = rem % 6;
      uq = 0;
      vq = 0;
      for (j = 0; j < ord; j++) begin
        uq |= ((quad >> (2 * j)) & 1) << j;
        vq |= ((quad >> (2 * j + 1)) & 1) << j;
      end
      n = 1 << ord;
      u = 2 * (int'(uq) + int'(CORNER_U[corner])) - int'(n);
      v = 2 * (int'(vq) + int'(CORNER_V[corner])) - int'(n);
      fx = face[0] ? int'(n) : -int'(n);
      if (face < 2) begin
        x = u; y = v; z = fx;
      end else if (face < 4) begin
        x = u; y = fx; z = v;
      end else begin
        x = fx; y = u; z = v;
      end
      len2 = 64'(x * x + y * y + z * z);
      e.x = normalize_axis(x, len2);
      e.y = normalize_axis(y, len2);
      e.z = normalize_axis(z, len2);
      e.valid = 1'b1;
      return e;
    endfunction

    function void note_index(logic [csvg_pkg::IDX_W-1:0] idx);
      awaited.push_back(project_vertex(idx));
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (awaited.size() == 0) begin
        $error("unexpected vertex_number %0d with no transfer pending", got.number);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      if (got.number !== e.number) begin
        $error("vertex_number expected %0d got %0d", e.number, got.number);
        mismatches++;
      end
      if (got.x !== e.x) begin
        $error("pos_x (vertex %0d) expected %0d got %0d", e.number, e.x, got.x);
        mismatches++;
      end
      if (got.y !== e.y) begin
        $error("pos_y (vertex %0d) expected %0d got %0d", e.number, e.y, got.y);
        mismatches++;
      end
      if (got.z !== e.z) begin
        $error("pos_z (vertex %0d) expected %0d got %0d", e.number, e.z, got.z);
        mismatches++;
      end
      if (got.valid !== e.valid) begin
        $error("index_valid (vertex %0d) expected %0b got %0b", e.number, e.valid, got.valid);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [csvg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [csvg_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit no_idle = 1'b0;
  int cycles = 0;
  vertex_book book;

  csvg_in_if  in_vtx();
  csvg_out_if out_vtx();

  cube_sphere_vertex_generator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (in_vtx),
    .out_vtx  (out_vtx),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // each call starts and ends at a falling edge
  task automatic send_index(input logic [csvg_pkg::IDX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_vtx.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_vtx.valid = 1'b1;
    in_vtx.vertex_index = idx;
    do @(posedge clk); while (!in_vtx.ready);
    book.note_index(idx);
    @(negedge clk);
  endtask

  task automatic drain();
    in_vtx.valid = 1'b0;
    while (book.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [csvg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csvg_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == csvg_pkg::CFG_RADIUS) book.set_radius(data[csvg_pkg::RAD_W-1:0]);
    else book.set_order(data[csvg_pkg::ORD_W-1:0]);
  endtask

  // order write with noise in the unused upper bits
  task automatic write_order(input logic [csvg_pkg::ORD_W-1:0] o);
    logic [csvg_pkg::CFG_DATA_W-1:0] d;
    d = cfg_data_t'($urandom);
    d[csvg_pkg::ORD_W-1:0] = o;
    write_reg(csvg_pkg::CFG_ORDER, d);
  endtask

  // result side: random stalls plus one long hold-off to back the pipe up
  initial begin
    int stall;
    int seen;
    bit held;
    vertex_t got;
    seen = 0;
    held = 1'b0;
    out_vtx.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (!held && seen >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        out_vtx.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_vtx.ready = 1'b1;
      do @(posedge clk); while (!out_vtx.valid);
      got.number = out_vtx.vertex_number;
      got.x = out_vtx.pos_x;
      got.y = out_vtx.pos_y;
      got.z = out_vtx.pos_z;
      got.valid = out_vtx.index_valid;
      book.check_vertex(got);
      seen++;
    end
  end

  initial begin
    logic [csvg_pkg::RAD_W-1:0] rad;
    logic [csvg_pkg::ORD_W-1:0] ord;
    int unsigned eff, lim, pick, k, p;
    book = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = csvg_pkg::CFG_RADIUS;
    cfg_wdata = '0;
    in_vtx.valid = 1'b0;
    in_vtx.vertex_index = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: unit radius, one quad per face
    send_index(0);
    send_index(1);
    send_index(2);
    send_index(3);
    send_index(4);
    send_index(5);
    send_index(6);
    send_index(12);
    send_index(35);
    send_index(36);
    send_index(18'h3FFFF);
    drain();

    // zero radius
    write_reg(csvg_pkg::CFG_RADIUS, 16'd0);
    send_index(7);
    send_index(30);
    drain();

    // largest radius, deepest order
    write_reg(csvg_pkg::CFG_RADIUS, 16'hFFFF);
    write_order(3'd6);
    send_index(0);
    send_index(147455);
    send_index(147456);
    send_index(131071);
    send_index(87381);
    drain();

    // order above the maximum behaves as the maximum
    write_order(3'd7);
    send_index(147455);
    send_index(147456);
    send_index(100000);
    drain();

    write_reg(csvg_pkg::CFG_RADIUS, 16'd1);
    write_order(3'd3);
    send_index(0);
    send_index(2303);
    send_index(2304);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin rad = 16'hFFFF; ord = 3'd6; end
        1: begin rad = 16'd0;    ord = 3'd2; end
        2: begin rad = 16'd1;    ord = 3'd7; end
        5: begin rad = 16'd256;  ord = 3'd0; end
        default: begin
          rad = radius_t'($urandom_range(0, 65535));
          ord = order_t'($urandom_range(0, 7));
        end
      endcase
      write_reg(csvg_pkg::CFG_RADIUS, rad);
      write_order(ord);
      no_idle = (p == 3 || p == 5);
      eff = (ord > csvg_pkg::MAX_ORDER_DEF) ? csvg_pkg::MAX_ORDER_DEF : 32'(ord);
      lim = csvg_pkg::NUM_FACES * (6 << (2 * eff));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) send_index(index_t'($urandom_range(0, lim - 1)));
        else if (pick == 8) send_index(index_t'(lim - 3 + $urandom_range(0, 5)));
        else send_index(index_t'($urandom));
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
